FILE: src/ddo_pkg.sv
// Shared types, constants and helper functions for the differential-drive odometry block.
package ddo_pkg;

  // Fixed datapath widths.
  localparam int unsigned VAL_W = 32;
  localparam int unsigned PROD_W = 68;
  localparam int unsigned DIVR_W = 48;
  localparam int unsigned SUM_W = 40;
  localparam int unsigned CFG_IDX_W = 3;

  // CORDIC and unit-conversion constants.
  localparam int unsigned CORDIC_STEPS = 30;
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
  localparam logic [29:0] RAD_TO_BAM = 30'd683565276;
  localparam logic [19:0] US_PER_S = 20'd1000000;
  localparam logic [31:0] MIN_DT_US = 32'd1000;

  // Configuration reset values.
  localparam logic [23:0] RADIUS_RST = 24'd6554;
  localparam logic [23:0] SEPARATION_RST = 24'd32768;
  localparam logic [4:0] WINDOW_RST = 5'd16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE,
    REG_RADIUS,
    REG_SEPARATION,
    REG_WINDOW,
    REG_START
  } reg_idx_t;

  // Controller states.
  typedef enum logic [5:0] {
    ST_IDLE, ST_MUL_L, ST_MUL_R, ST_DIFF, ST_LIN, ST_TURN_W, ST_MUL_BAM, ST_BAM,
    ST_COR0_W, ST_COR1_W, ST_MUL_CX, ST_MUL_SY, ST_DY0, ST_MUL_NX, ST_DIVX_GO,
    ST_DIVX_W, ST_MUL_NY, ST_DIVY_GO, ST_DIVY_W, ST_POSE, ST_MUL_VL, ST_DIVVL_GO,
    ST_DIVVL_W, ST_MUL_VA, ST_DIVVA_GO, ST_DIVVA_W, ST_WIN, ST_AVGL_GO, ST_AVGL_W,
    ST_AVGA_GO, ST_AVGA_W, ST_OUT
  } state_t;

  // Datapath commands.
  typedef enum logic [5:0] {
    OP_IDLE, OP_LOAD, OP_MUL_L, OP_MUL_R, OP_DIFF, OP_LIN, OP_TURN, OP_MUL_BAM,
    OP_BAM, OP_COR0, OP_COR1, OP_MUL_CX, OP_MUL_SY, OP_DY_ZERO, OP_MUL_NX,
    OP_DIV_ARC, OP_DX, OP_MUL_NY, OP_DY, OP_POSE, OP_MUL_VL, OP_DIV_VEL, OP_VL,
    OP_MUL_VA, OP_VA, OP_WIN, OP_DIV_AVGL, OP_AVGL, OP_DIV_AVGA, OP_AVGA, OP_OUT
  } op_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic div_done;
    logic cor_done;
    logic turn_zero;
    logic upd;
    logic fill_zero;
    logic out_busy;
  } sts_t;

  // Arctangent of 2^-i as a binary angle.
  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0: a = 32'd536870912;
      5'd1: a = 32'd316933406;
      5'd2: a = 32'd167458907;
      5'd3: a = 32'd85004756;
      5'd4: a = 32'd42667331;
      5'd5: a = 32'd21354465;
      5'd6: a = 32'd10679838;
      5'd7: a = 32'd5340245;
      5'd8: a = 32'd2670163;
      5'd9: a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > 68'sh0_0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -68'sh0_0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: src/ddo_if.sv
// Handshake channel interfaces: wheel samples, pose results and configuration writes.
interface ddo_sample_if;
  logic valid;
  logic ready;
  logic signed [31:0] left_wheel;
  logic signed [31:0] right_wheel;
  logic [31:0] timestamp_us;
  modport source(output valid, left_wheel, right_wheel, timestamp_us, input ready);
  modport sink(input valid, left_wheel, right_wheel, timestamp_us, output ready);
endinterface

interface ddo_pose_if;
  logic valid;
  logic ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic [31:0] heading;
  logic signed [31:0] est_linear_velocity;
  logic signed [31:0] est_angular_velocity;
  logic velocity_updated;
  modport source(output valid, pose_x, pose_y, heading, est_linear_velocity,
                 est_angular_velocity, velocity_updated, input ready);
  modport sink(input valid, pose_x, pose_y, heading, est_linear_velocity,
               est_angular_velocity, velocity_updated, output ready);
endinterface

interface ddo_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: src/ddo_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ddo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/ddo_div.sv
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
module ddo_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [ddo_pkg::PROD_W-1:0]   dividend,
  input  logic signed [ddo_pkg::DIVR_W-1:0]   divisor,
  output logic                                done,
  output logic signed [ddo_pkg::PROD_W-1:0]   quotient
);

  localparam int NW = ddo_pkg::PROD_W;
  localparam int DW = ddo_pkg::DIVR_W;

  logic          busy;
  logic [6:0]    cnt;
  logic          neg;
  logic [NW-1:0] num;
  logic [DW-1:0] den;
  logic [DW-1:0] rem;
  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW:0]   rem_sub;

  // One shift-and-subtract step.
  assign rem_sh = {rem, num[NW-1]};
  assign ge = rem_sh >= {1'b0, den};
  assign rem_sub = ge ? (rem_sh - {1'b0, den}) : rem_sh;

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand magnitudes and partial results.
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
      den <= divisor[DW-1] ? DW'(-divisor) : DW'(divisor);
      rem <= '0;
      neg <= dividend[NW-1] ^ divisor[DW-1];
    end else if (busy) begin
      rem <= rem_sub[DW-1:0];
      num <= {num[NW-2:0], ge};
    end
  end

  // The quotient sign is applied to the magnitude.
  assign quotient = neg ? -$signed(num) : $signed(num);

endmodule

FILE: src/ddo_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle in Q2.30.
module ddo_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [31:0] cos_val,
  output logic signed [31:0] sin_val
);

  logic               busy;
  logic [4:0]         step;
  logic               flip;
  logic               start_flip;
  logic [31:0]        start_angle;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic signed [33:0] x_sh;
  logic signed [33:0] y_sh;
  logic signed [33:0] atn;

  // Fold the second and third quadrants onto the right half plane.
  assign start_flip = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
  assign start_angle = start_flip ? (angle + 32'h8000_0000) : angle;

  assign x_sh = x >>> step;
  assign y_sh = y >>> step;
  assign atn = $signed({2'b00, ddo_pkg::atan_bam(step)});

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'(ddo_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Micro-rotations.
  always_ff @(posedge clk) begin
    if (start) begin
      x <= $signed({2'b00, ddo_pkg::CORDIC_GAIN});
      y <= '0;
      z <= 34'($signed(start_angle));
      flip <= start_flip;
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - y_sh;
        y <= y + x_sh;
        z <= z - atn;
      end else begin
        x <= x + y_sh;
        y <= y - x_sh;
        z <= z + atn;
      end
    end
  end

  assign cos_val = 32'(flip ? -x : x);
  assign sin_val = 32'(flip ? -y : y);

endmodule

FILE: src/ddo_ctrl.sv
// Sequencer that steps the odometry datapath through one update per accepted sample.
module ddo_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ddo_pkg::sts_t    sts,
  output ddo_pkg::op_t     op
);

  ddo_pkg::state_t state;
  ddo_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ddo_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_next = state;
    op = ddo_pkg::OP_IDLE;
    in_ready = 1'b0;
    case (state)
      ddo_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = ddo_pkg::OP_LOAD;
          state_next = ddo_pkg::ST_MUL_L;
        end
      end
      ddo_pkg::ST_MUL_L: begin
        op = ddo_pkg::OP_MUL_L;
        state_next = ddo_pkg::ST_MUL_R;
      end
      ddo_pkg::ST_MUL_R: begin
        op = ddo_pkg::OP_MUL_R;
        state_next = ddo_pkg::ST_DIFF;
      end
      ddo_pkg::ST_DIFF: begin
        op = ddo_pkg::OP_DIFF;
        state_next = ddo_pkg::ST_LIN;
      end
      ddo_pkg::ST_LIN: begin
        op = ddo_pkg::OP_LIN;
        state_next = ddo_pkg::ST_TURN_W;
      end
      ddo_pkg::ST_TURN_W: begin
        if (sts.div_done) begin
          op = ddo_pkg::OP_TURN;
          state_next = ddo_pkg::ST_MUL_BAM;
        end
      end
      ddo_pkg::ST_MUL_BAM: begin
        op = ddo_pkg::OP_MUL_BAM;
        state_next = ddo_pkg::ST_BAM;
      end
      ddo_pkg::ST_BAM: begin
        op = ddo_pkg::OP_BAM;
        state_next = ddo_pkg::ST_COR0_W;
      end
      ddo_pkg::ST_COR0_W: begin
        if (sts.cor_done) begin
          op = ddo_pkg::OP_COR0;
          state_next = sts.turn_zero ? ddo_pkg::ST_MUL_CX : ddo_pkg::ST_COR1_W;
        end
      end
      ddo_pkg::ST_COR1_W: begin
        if (sts.cor_done) begin
          op = ddo_pkg::OP_COR1;
          state_next = ddo_pkg::ST_MUL_NX;
        end
      end
      ddo_pkg::ST_MUL_CX: begin
        op = ddo_pkg::OP_MUL_CX;
        state_next = ddo_pkg::ST_MUL_SY;
      end
      ddo_pkg::ST_MUL_SY: begin
        op = ddo_pkg::OP_MUL_SY;
        state_next = ddo_pkg::ST_DY0;
      end
      ddo_pkg::ST_DY0: begin
        op = ddo_pkg::OP_DY_ZERO;
        state_next = ddo_pkg::ST_POSE;
      end
      ddo_pkg::ST_MUL_NX: begin
        op = ddo_pkg::OP_MUL_NX;
        state_next = ddo_pkg::ST_DIVX_GO;
      end
      ddo_pkg::ST_DIVX_GO: begin
        op = ddo_pkg::OP_DIV_ARC;
        state_next = ddo_pkg::ST_DIVX_W;
      end
      ddo_pkg::ST_DIVX_W: begin
        if (sts.div_done) begin
          op = ddo_pkg::OP_DX;
          state_next = ddo_pkg::ST_MUL_NY;
        end
      end
      ddo_pkg::ST_MUL_NY: begin
        op = ddo_pkg::OP_MUL_NY;
        state_next = ddo_pkg::ST_DIVY_GO;
      end
      ddo_pkg::ST_DIVY_GO: begin
        op = ddo_pkg::OP_DIV_ARC;
        state_next = ddo_pkg::ST_DIVY_W;
      end
      ddo_pkg::ST_DIVY_W: begin
        if (sts.div_done) begin
          op = ddo_pkg::OP_DY;
          state_next = ddo_pkg::ST_POSE;
        end
      end
      ddo_pkg::ST_POSE: begin
        op = ddo_pkg::OP_POSE;
        if (sts.upd) begin
          state_next = ddo_pkg::ST_MUL_VL;
        end else if (sts.fill_zero) begin
          state_next = ddo_pkg::ST_OUT;
        end else begin
          state_next = ddo_pkg::ST_AVGL_GO;
        end
      end
      ddo_pkg::ST_MUL_VL: begin
        op = ddo_pkg::OP_MUL_VL;
        state_next = ddo_pkg::ST_DIVVL_GO;
      end
      ddo_pkg::ST_DIVVL_GO: begin
        op = ddo_pkg::OP_DIV_VEL;
        state_next = ddo_pkg::ST_DIVVL_W;
      end
      ddo_pkg::ST_DIVVL_W: begin
        if (sts.div_done) begin
          op = ddo_pkg::OP_VL;
          state_next = ddo_pkg::ST_MUL_VA;
        end
      end
      ddo_pkg::ST_MUL_VA: begin
        op = ddo_pkg::OP_MUL_VA;
        state_next = ddo_pkg::ST_DIVVA_GO;
      end
      ddo_pkg::ST_DIVVA_GO: begin
        op = ddo_pkg::OP_DIV_VEL;
        state_next = ddo_pkg::ST_DIVVA_W;
      end
      ddo_pkg::ST_DIVVA_W: begin
        if (sts.div_done) begin
          op = ddo_pkg::OP_VA;
          state_next = ddo_pkg::ST_WIN;
        end
      end
      ddo_pkg::ST_WIN: begin
        op = ddo_pkg::OP_WIN;
        state_next = ddo_pkg::ST_AVGL_GO;
      end
      ddo_pkg::ST_AVGL_GO: begin
        op = ddo_pkg::OP_DIV_AVGL;
        state_next = ddo_pkg::ST_AVGL_W;
      end
      ddo_pkg::ST_AVGL_W: begin
        if (sts.div_done) begin
          op = ddo_pkg::OP_AVGL;
          state_next = ddo_pkg::ST_AVGA_GO;
        end
      end
      ddo_pkg::ST_AVGA_GO: begin
        op = ddo_pkg::OP_DIV_AVGA;
        state_next = ddo_pkg::ST_AVGA_W;
      end
      ddo_pkg::ST_AVGA_W: begin
        if (sts.div_done) begin
          op = ddo_pkg::OP_AVGA;
          state_next = ddo_pkg::ST_OUT;
        end
      end
      ddo_pkg::ST_OUT: begin
        if (!sts.out_busy) begin
          op = ddo_pkg::OP_OUT;
          state_next = ddo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ddo_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/ddo_dp.sv
// Odometry datapath: configuration, pose state, shared multiplier, divider, CORDIC and windows.
module ddo_dp #(
  parameter int WINDOW_MAX = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  ddo_pkg::op_t        op,
  output ddo_pkg::sts_t       sts,
  input  logic signed [31:0]  in_left,
  input  logic signed [31:0]  in_right,
  input  logic [31:0]         in_ts,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  ddo_pose_if.source          pose
);

  localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FW = $clog2(WINDOW_MAX + 1);
  localparam int NW = ddo_pkg::PROD_W;
  localparam int DW = ddo_pkg::DIVR_W;
  localparam int SW = ddo_pkg::SUM_W;

  // Configuration.
  logic        mode;
  logic [23:0] radius;
  logic [23:0] sep;
  logic [4:0]  wlen;

  // Per-item working registers.
  logic signed [31:0] l_in;
  logic signed [31:0] r_in;
  logic [31:0]        ts_in;
  logic signed [31:0] cl;
  logic signed [32:0] dl;
  logic signed [32:0] dr;
  logic signed [31:0] lin;
  logic signed [31:0] turn;
  logic [31:0]        tb;
  logic signed [31:0] c0;
  logic signed [31:0] s0;
  logic signed [31:0] c1;
  logic signed [31:0] s1;
  logic signed [NW-1:0] prod;
  logic signed [NW-1:0] dx;
  logic signed [NW-1:0] dy;
  logic [31:0]        dt;
  logic               upd_r;
  logic signed [31:0] vl;
  logic signed [31:0] va;
  logic signed [31:0] avgl;
  logic signed [31:0] avga;

  // Persistent state.
  logic signed [31:0] x_pos;
  logic signed [31:0] y_pos;
  logic [31:0]        hd;
  logic signed [31:0] prev_l;
  logic signed [31:0] prev_r;
  logic [31:0]        last_time;
  logic signed [SW-1:0] lsum;
  logic signed [SW-1:0] asum;
  logic [FW-1:0]      fill;
  logic [PW-1:0]      ptr;

  // Combinational helpers.
  logic signed [33:0]   ma;
  logic signed [33:0]   mb;
  logic signed [NW-1:0] mul_p;
  logic                 mul_en;
  logic signed [32:0]   turn_ext;
  logic signed [32:0]   turn_abs;
  logic signed [33:0]   s_diff;
  logic signed [33:0]   c_diff;
  logic signed [33:0]   sum34;
  logic signed [33:0]   diff34;
  logic signed [31:0]   cr_c;
  logic [47:0]          bam_sum;
  logic [31:0]          bam_mag;
  logic [31:0]          dt_c;
  logic                 upd_c;
  logic [23:0]          sep_eff;
  logic [FW-1:0]        n_eff;
  logic                 full;
  logic [PW:0]          ptr_inc;
  logic [31:0]          rd_l;
  logic [31:0]          rd_a;

  // Divider and CORDIC hookup.
  logic                 div_start;
  logic signed [NW-1:0] div_dd;
  logic signed [DW-1:0] div_dv;
  logic                 div_done;
  logic signed [NW-1:0] div_q;
  logic                 cor_start;
  logic [31:0]          cor_angle;
  logic                 cor_done;
  logic signed [31:0]   cor_c;
  logic signed [31:0]   cor_s;

  assign turn_ext = 33'(turn);
  assign turn_abs = turn[31] ? -turn_ext : turn_ext;
  assign s_diff = 34'(s1) - 34'(s0);
  assign c_diff = 34'(c0) - 34'(c1);
  assign sum34 = 34'(dl) + 34'(dr);
  assign diff34 = 34'(dr) - 34'(dl);
  assign cr_c = ddo_pkg::sat32(prod >>> 16);
  assign bam_sum = prod[47:0] + 48'd32768;
  assign bam_mag = bam_sum[47:16];
  assign dt_c = ts_in - last_time;
  assign upd_c = dt_c >= ddo_pkg::MIN_DT_US;
  assign sep_eff = (sep == 24'd0) ? 24'd1 : sep;
  assign full = fill >= n_eff;
  assign ptr_inc = {1'b0, ptr} + (PW+1)'(1);

  // Effective window length, clamped to the storage depth.
  always_comb begin
    if (wlen == 5'd0) begin
      n_eff = FW'(1);
    end else if (int'(wlen) > WINDOW_MAX) begin
      n_eff = FW'(WINDOW_MAX);
    end else begin
      n_eff = FW'(wlen);
    end
  end

  // Multiplier operand selection.
  always_comb begin
    ma = '0;
    mb = '0;
    mul_en = 1'b1;
    case (op)
      ddo_pkg::OP_MUL_L: begin
        ma = 34'(l_in);
        mb = $signed({10'd0, radius});
      end
      ddo_pkg::OP_MUL_R: begin
        ma = 34'(r_in);
        mb = $signed({10'd0, radius});
      end
      ddo_pkg::OP_MUL_BAM: begin
        ma = 34'(turn_abs);
        mb = $signed({4'd0, ddo_pkg::RAD_TO_BAM});
      end
      ddo_pkg::OP_MUL_CX: begin
        ma = 34'(lin);
        mb = 34'(c0);
      end
      ddo_pkg::OP_MUL_SY: begin
        ma = 34'(lin);
        mb = 34'(s0);
      end
      ddo_pkg::OP_MUL_NX: begin
        ma = 34'(lin);
        mb = s_diff;
      end
      ddo_pkg::OP_MUL_NY: begin
        ma = 34'(lin);
        mb = c_diff;
      end
      ddo_pkg::OP_MUL_VL: begin
        ma = 34'(lin);
        mb = $signed({14'd0, ddo_pkg::US_PER_S});
      end
      ddo_pkg::OP_MUL_VA: begin
        ma = 34'(turn);
        mb = $signed({14'd0, ddo_pkg::US_PER_S});
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign mul_p = ma * mb;

  // Divider operand selection.
  always_comb begin
    div_start = 1'b1;
    div_dd = prod;
    div_dv = '0;
    case (op)
      ddo_pkg::OP_LIN: begin
        div_dd = {{18{diff34[33]}}, diff34, 16'd0};
        div_dv = $signed({24'd0, sep_eff});
      end
      ddo_pkg::OP_DIV_ARC: begin
        div_dv = {{2{turn[31]}}, turn, 14'd0};
      end
      ddo_pkg::OP_DIV_VEL: begin
        div_dv = $signed({16'd0, dt});
      end
      ddo_pkg::OP_DIV_AVGL: begin
        div_dd = NW'(lsum);
        div_dv = $signed(DW'(fill));
      end
      ddo_pkg::OP_DIV_AVGA: begin
        div_dd = NW'(asum);
        div_dv = $signed(DW'(fill));
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // The second CORDIC run takes the heading after the turn.
  assign cor_start = (op == ddo_pkg::OP_BAM) || ((op == ddo_pkg::OP_COR0) && (turn != 32'sd0));
  assign cor_angle = (op == ddo_pkg::OP_BAM) ? hd : (hd + tb);

  ddo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dd),
    .divisor  (div_dv),
    .done     (div_done),
    .quotient (div_q)
  );

  ddo_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .angle   (cor_angle),
    .done    (cor_done),
    .cos_val (cor_c),
    .sin_val (cor_s)
  );

  ddo_ram #(.WIDTH(32), .DEPTH(WINDOW_MAX)) u_lin_hist (
    .clk   (clk),
    .we    (op == ddo_pkg::OP_WIN),
    .waddr (ptr),
    .wdata (vl),
    .raddr (ptr),
    .rdata (rd_l)
  );

  ddo_ram #(.WIDTH(32), .DEPTH(WINDOW_MAX)) u_ang_hist (
    .clk   (clk),
    .we    (op == ddo_pkg::OP_WIN),
    .waddr (ptr),
    .wdata (va),
    .raddr (ptr),
    .rdata (rd_a)
  );

  // Working registers that need no reset.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_p;
    end
    case (op)
      ddo_pkg::OP_LOAD: begin
        l_in <= in_left;
        r_in <= in_right;
        ts_in <= in_ts;
      end
      ddo_pkg::OP_MUL_R: cl <= cr_c;
      ddo_pkg::OP_LIN: lin <= ddo_pkg::sat32(NW'(sum34 >>> 1));
      ddo_pkg::OP_TURN: turn <= ddo_pkg::sat32(div_q);
      ddo_pkg::OP_BAM: tb <= turn[31] ? (32'd0 - bam_mag) : bam_mag;
      ddo_pkg::OP_COR0: begin
        c0 <= cor_c;
        s0 <= cor_s;
      end
      ddo_pkg::OP_COR1: begin
        c1 <= cor_c;
        s1 <= cor_s;
      end
      ddo_pkg::OP_MUL_SY: dx <= prod >>> 30;
      ddo_pkg::OP_DY_ZERO: dy <= prod >>> 30;
      ddo_pkg::OP_DX: dx <= div_q;
      ddo_pkg::OP_DY: dy <= div_q;
      ddo_pkg::OP_POSE: begin
        dt <= dt_c;
        upd_r <= upd_c;
      end
      ddo_pkg::OP_VL: vl <= ddo_pkg::sat32(div_q);
      ddo_pkg::OP_VA: va <= ddo_pkg::sat32(div_q);
      ddo_pkg::OP_AVGL: avgl <= ddo_pkg::sat32(div_q);
      ddo_pkg::OP_AVGA: avga <= ddo_pkg::sat32(div_q);
      default: begin
      end
    endcase
  end

  // Configuration, pose and window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      radius <= ddo_pkg::RADIUS_RST;
      sep <= ddo_pkg::SEPARATION_RST;
      wlen <= ddo_pkg::WINDOW_RST;
      x_pos <= '0;
      y_pos <= '0;
      hd <= '0;
      prev_l <= '0;
      prev_r <= '0;
      last_time <= '0;
      lsum <= '0;
      asum <= '0;
      fill <= '0;
      ptr <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ddo_pkg::REG_MODE: mode <= cfg_data[0];
          ddo_pkg::REG_RADIUS: radius <= cfg_data[23:0];
          ddo_pkg::REG_SEPARATION: sep <= cfg_data[23:0];
          ddo_pkg::REG_WINDOW: begin
            wlen <= cfg_data[4:0];
            lsum <= '0;
            asum <= '0;
            fill <= '0;
            ptr <= '0;
          end
          ddo_pkg::REG_START: last_time <= cfg_data;
          default: begin
          end
        endcase
      end
      case (op)
        ddo_pkg::OP_DIFF: begin
          if (!mode) begin
            dl <= 33'(cl) - 33'(prev_l);
            dr <= 33'(cr_c) - 33'(prev_r);
            prev_l <= cl;
            prev_r <= cr_c;
          end else begin
            dl <= 33'(l_in);
            dr <= 33'(r_in);
          end
        end
        ddo_pkg::OP_POSE: begin
          x_pos <= ddo_pkg::sat32(NW'(x_pos) + dx);
          y_pos <= ddo_pkg::sat32(NW'(y_pos) + dy);
          hd <= hd + tb;
          if (mode || upd_c) begin
            last_time <= ts_in;
          end
        end
        ddo_pkg::OP_WIN: begin
          lsum <= lsum - (full ? SW'($signed(rd_l)) : SW'(0)) + SW'(vl);
          asum <= asum - (full ? SW'($signed(rd_a)) : SW'(0)) + SW'(va);
          if (!full) begin
            fill <= fill + FW'(1);
          end
          ptr <= (32'(ptr_inc) >= 32'(n_eff)) ? '0 : ptr_inc[PW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pose.valid <= 1'b0;
    end else if (op == ddo_pkg::OP_OUT) begin
      pose.valid <= 1'b1;
    end else if (pose.ready) begin
      pose.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == ddo_pkg::OP_OUT) begin
      pose.pose_x <= x_pos;
      pose.pose_y <= y_pos;
      pose.heading <= hd;
      pose.est_linear_velocity <= (fill == '0) ? 32'sd0 : avgl;
      pose.est_angular_velocity <= (fill == '0) ? 32'sd0 : avga;
      pose.velocity_updated <= upd_r;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.div_done = div_done;
    sts.cor_done = cor_done;
    sts.turn_zero = (turn == 32'sd0);
    sts.upd = upd_c;
    sts.fill_zero = (fill == '0);
    sts.out_busy = pose.valid && !pose.ready;
  end

endmodule

FILE: src/diff_drive_odometry.sv
// Top level of the differential-drive odometry block.
// Usage: each beat on the sample channel carries left and right wheel readings (Q16.16
// angles in position mode, per-update travel in travel mode) and a microsecond timestamp.
// For each sample one beat leaves on the pose channel with x, y, heading, the two
// rolling-mean velocity estimates and a flag that says whether the estimates took a new
// sample. Configuration beats on the cfg channel are always taken; write them only while
// no sample is in flight.
// The shared divider resolves one quotient bit per cycle over 68 bits and runs up to seven
// times per sample; the 30-step CORDIC runs once or twice. The block takes no new sample
// while one is in flight; the next sample is taken once the result has been moved into
// the output register.
// Reset clears the pose, previous wheel travel, time base and velocity windows, and loads
// the default configuration. A stalled receiver holds the finished result in the output
// register while the block takes and processes the next sample; that sample's result
// waits until the register frees up.
module diff_drive_odometry #(
  parameter int WINDOW_MAX = 16
) (
  input logic         clk,
  input logic         rst,
  ddo_sample_if.sink  sample,
  ddo_pose_if.source  pose,
  ddo_cfg_if.sink     cfg
);

  ddo_pkg::op_t  op;
  ddo_pkg::sts_t sts;
  logic          in_ready;

  assign sample.ready = in_ready;
  assign cfg.ready = 1'b1;

  ddo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .op       (op)
  );

  ddo_dp #(.WINDOW_MAX(WINDOW_MAX)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .sts       (sts),
    .in_left   (sample.left_wheel),
    .in_right  (sample.right_wheel),
    .in_ts     (sample.timestamp_us),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .pose      (pose)
  );

endmodule
